### design/imm_pkg.sv
// Shared types, constants and helpers for the integer matrix multiplier.
// Used by imm_front, imm_back and the top level; depends on nothing.
package imm_pkg;

  localparam int MAX_DIM_DEFAULT = 8;
  localparam int CFG_W           = 4;   // width of each dimension register
  localparam int DIM_W           = 5;   // holds a saturated dimension up to 16
  localparam int IDX_W           = 2;   // register index width
  localparam int WORD_W          = 32;
  localparam int OUT_IDX_W       = 3;

  localparam logic [IDX_W-1:0] REG_ROWS_A     = 2'd0;
  localparam logic [IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [IDX_W-1:0] REG_COLS_B     = 2'd2;

  localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

  typedef struct packed {
    logic [DIM_W-1:0] nr;
    logic [DIM_W-1:0] nk;
    logic [DIM_W-1:0] nc;
  } dims_t;

  // zero reads as one, anything above the limit saturates
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] r,
                                               input logic [DIM_W-1:0] maxd);
    logic [DIM_W-1:0] v;
    v = DIM_W'(r);
    if (v == '0) v = DIM_W'(1);
    if (v > maxd) v = maxd;
    return v;
  endfunction

endpackage

### design/integer_matrix_multiply.sv
// Integer matrix multiplier: loads A then B one element per transfer, then
// streams C = A x B row-major. Elements enter a two-entry queue one per cycle
// while it is not full; popping the element that completes B starts a burst
// of rows*cols*inner reads, one product term per cycle unless the output
// stalls. Input stalls once the queue fills during the burst. Synchronous reset
// clears control and sets all dimensions to 8; the stores are not cleared.
module integer_matrix_multiply #(
  parameter int MAX_DIM = imm_pkg::MAX_DIM_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [imm_pkg::IDX_W-1:0]         cfg_index,
  input  logic [imm_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [imm_pkg::WORD_W-1:0] element_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [imm_pkg::OUT_IDX_W-1:0]     out_row,
  output logic [imm_pkg::OUT_IDX_W-1:0]     out_col,
  output logic signed [imm_pkg::WORD_W-1:0] product_value,
  output logic                              last_of_run
);

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int EW = imm_pkg::WORD_W + AW + 2;

  imm_pkg::dims_t dims;
  logic           q_push, q_pop, q_full, q_empty;
  logic [EW-1:0]  push_entry, pop_entry;

  imm_front #(.MAX_DIM(MAX_DIM), .AW(AW), .EW(EW)) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .element_value (element_value),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (push_entry),
    .dims          (dims)
  );

  imm_queue #(.EW(EW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_entry),
    .pop       (q_pop),
    .pop_data  (pop_entry),
    .full      (q_full),
    .empty     (q_empty)
  );

  imm_back #(.MAX_DIM(MAX_DIM), .AW(AW), .EW(EW)) u_back (
    .clk           (clk),
    .rst           (rst),
    .dims          (dims),
    .q_empty       (q_empty),
    .q_entry       (pop_entry),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row       (out_row),
    .out_col       (out_col),
    .product_value (product_value),
    .last_of_run   (last_of_run)
  );

endmodule

### design/imm_front.sv
// Front end: dimension registers, load counter and element classification.
// Tags each element with its store, address and end-of-load mark. Uses imm_pkg.
module imm_front #(
  parameter int MAX_DIM = imm_pkg::MAX_DIM_DEFAULT,
  parameter int AW      = 6,
  parameter int EW      = 40
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [imm_pkg::IDX_W-1:0]    cfg_index,
  input  logic [imm_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [imm_pkg::WORD_W-1:0] element_value,
  input  logic                         q_full,
  output logic                         q_push,
  output logic [EW-1:0]                q_entry,
  output imm_pkg::dims_t               dims
);

  localparam int CW = $clog2(2 * MAX_DIM * MAX_DIM + 1);

  logic [imm_pkg::CFG_W-1:0] rows_a;
  logic [imm_pkg::CFG_W-1:0] inner_size;
  logic [imm_pkg::CFG_W-1:0] cols_b;
  logic [CW-1:0]             load_count;

  logic [CW-1:0] a_total;
  logic [CW-1:0] total;
  logic          is_b;
  logic          is_last;
  logic [AW-1:0] addr;

  assign dims.nr = imm_pkg::eff_dim(rows_a, imm_pkg::DIM_W'(MAX_DIM));
  assign dims.nk = imm_pkg::eff_dim(inner_size, imm_pkg::DIM_W'(MAX_DIM));
  assign dims.nc = imm_pkg::eff_dim(cols_b, imm_pkg::DIM_W'(MAX_DIM));

  assign a_total = CW'(dims.nr) * CW'(dims.nk);
  assign total   = a_total + CW'(dims.nk) * CW'(dims.nc);
  assign is_b    = load_count >= a_total;
  assign addr    = is_b ? AW'(load_count - a_total) : AW'(load_count);
  assign is_last = (load_count + 1'b1) == total;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_entry  = {is_last, is_b, addr, element_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a     <= imm_pkg::DIM_RESET;
      inner_size <= imm_pkg::DIM_RESET;
      cols_b     <= imm_pkg::DIM_RESET;
      load_count <= '0;
    end else if (cfg_write) begin
      // any valid register write restarts loading
      unique case (cfg_index)
        imm_pkg::REG_ROWS_A: begin
          rows_a     <= cfg_data;
          load_count <= '0;
        end
        imm_pkg::REG_INNER_SIZE: begin
          inner_size <= cfg_data;
          load_count <= '0;
        end
        imm_pkg::REG_COLS_B: begin
          cols_b     <= cfg_data;
          load_count <= '0;
        end
        default: ;
      endcase
    end else if (q_push) begin
      load_count <= is_last ? '0 : load_count + 1'b1;
    end
  end

endmodule

### design/imm_queue.sv
// Two-entry FIFO between the front end and the compute back end.
// Generic payload width; no package dependencies.
module imm_queue #(
  parameter int EW = 40
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [EW-1:0] push_data,
  input  logic          pop,
  output logic [EW-1:0] pop_data,
  output logic          full,
  output logic          empty
);

  logic [EW-1:0] slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign full     = fill == 2'd2;
  assign empty    = fill == 2'd0;
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

### design/imm_back.sv
// Back end: A and B stores, dot-product sequencer, read/multiply/accumulate
// pipeline and the output register. Uses imm_pkg.
module imm_back #(
  parameter int MAX_DIM = imm_pkg::MAX_DIM_DEFAULT,
  parameter int AW      = 6,
  parameter int EW      = 40
) (
  input  logic                              clk,
  input  logic                              rst,
  input  imm_pkg::dims_t                    dims,
  input  logic                              q_empty,
  input  logic [EW-1:0]                     q_entry,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [imm_pkg::OUT_IDX_W-1:0]     out_row,
  output logic [imm_pkg::OUT_IDX_W-1:0]     out_col,
  output logic signed [imm_pkg::WORD_W-1:0] product_value,
  output logic                              last_of_run
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int WW    = imm_pkg::WORD_W;

  typedef enum logic {LOAD, COMPUTE} state_t;

  typedef struct packed {
    logic          first;
    logic          last;
    logic          run_end;
    logic [IW-1:0] row;
    logic [IW-1:0] col;
  } tag_t;

  logic [WW-1:0] store_a [DEPTH];
  logic [WW-1:0] store_b [DEPTH];

  state_t        state;
  logic [IW-1:0] i_cnt, j_cnt, k_cnt;
  logic [AW-1:0] a_ptr, a_base, b_ptr;

  logic          s1_valid, s2_valid;
  tag_t          s1_tag, s2_tag, issue_tag;
  logic [WW-1:0] rd_a, rd_b, s2_prod, acc, acc_sum;

  logic          e_last, e_is_b;
  logic [AW-1:0] e_addr;
  logic [WW-1:0] e_data;

  logic adv, issue, k_end, j_end, i_end;

  assign {e_last, e_is_b, e_addr, e_data} = q_entry;

  assign q_pop = (state == LOAD) && !q_empty;
  assign issue = state == COMPUTE;
  // the whole pipeline holds while a finished sum cannot enter the output register
  assign adv   = !(s2_valid && s2_tag.last && out_valid && out_stall);

  assign k_end = imm_pkg::DIM_W'(k_cnt) == dims.nk - 1'b1;
  assign j_end = imm_pkg::DIM_W'(j_cnt) == dims.nc - 1'b1;
  assign i_end = imm_pkg::DIM_W'(i_cnt) == dims.nr - 1'b1;

  assign issue_tag.first   = k_cnt == '0;
  assign issue_tag.last    = k_end;
  assign issue_tag.run_end = k_end && j_end && i_end;
  assign issue_tag.row     = i_cnt;
  assign issue_tag.col     = j_cnt;

  assign acc_sum = (s2_tag.first ? '0 : acc) + s2_prod;

  // store writes and registered reads
  always_ff @(posedge clk) begin
    if (q_pop && !e_is_b) store_a[e_addr] <= e_data;
    if (adv && issue) rd_a <= store_a[a_ptr];
  end

  always_ff @(posedge clk) begin
    if (q_pop && e_is_b) store_b[e_addr] <= e_data;
    if (adv && issue) rd_b <= store_b[b_ptr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
    end else begin
      unique case (state)
        LOAD: begin
          if (q_pop && e_last) begin
            state  <= COMPUTE;
            i_cnt  <= '0;
            j_cnt  <= '0;
            k_cnt  <= '0;
            a_ptr  <= '0;
            a_base <= '0;
            b_ptr  <= '0;
          end
        end
        COMPUTE: begin
          if (adv) begin
            if (!k_end) begin
              k_cnt <= k_cnt + 1'b1;
              a_ptr <= a_ptr + 1'b1;
              b_ptr <= b_ptr + AW'(dims.nc);
            end else begin
              k_cnt <= '0;
              if (!j_end) begin
                j_cnt <= j_cnt + 1'b1;
                a_ptr <= a_base;
                b_ptr <= AW'(j_cnt) + 1'b1;
              end else begin
                j_cnt  <= '0;
                i_cnt  <= i_cnt + 1'b1;
                a_base <= a_base + AW'(dims.nk);
                a_ptr  <= a_base + AW'(dims.nk);
                b_ptr  <= '0;
                if (i_end) state <= LOAD;
              end
            end
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

  // read -> multiply -> accumulate pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag  <= issue_tag;
      s2_tag  <= s1_tag;
      s2_prod <= rd_a * rd_b;   // low word only, wraps like C int
      if (s2_valid && !s2_tag.last) acc <= acc_sum;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && s2_valid && s2_tag.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid && s2_tag.last) begin
      out_row       <= imm_pkg::OUT_IDX_W'(s2_tag.row);
      out_col       <= imm_pkg::OUT_IDX_W'(s2_tag.col);
      product_value <= acc_sum;
      last_of_run   <= s2_tag.run_end;
    end
  end

endmodule
